[hdl/terminal_input_line_buffer_core_macros.svh]
// ---------------------------------------------------------------------------
// Terminal input line buffer: assertion macros
// Shared helpers for the concurrent checks on the line buffer's ports.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_INPUT_LINE_BUFFER_CORE_MACROS_SVH
`define TERMINAL_INPUT_LINE_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define TILB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define TILB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tilb_pkg.sv]
// ---------------------------------------------------------------------------
// Terminal input line buffer: package
// Sizes, character codes and the item and control structures of the block.
// ---------------------------------------------------------------------------
package tilb_pkg;

    // Line store size and the widths that follow from it.
    localparam int LINE_CAPACITY = 4096;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LINE_CAPACITY);

    // Character codes.
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_EOT = 8'h04;

    // Input item function codes.
    localparam logic FUNC_RX  = 1'b0;
    localparam logic FUNC_REQ = 1'b1;

    // Result destination codes.
    localparam logic DEST_ECHO   = 1'b0;
    localparam logic DEST_READER = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       dest;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // Description of the results one input item produces.
    typedef struct packed {
        logic       valid;
        logic       dest;
        logic       use_mem;
        logic       two;
        logic [7:0] byte0;
    } res_desc_t;

    // Line store access requested by the control logic.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

[hdl/terminal_input_line_buffer_core.sv]
// ---------------------------------------------------------------------------
// Terminal input line buffer core
// Canonical-mode terminal input: echo, line gathering and reader delivery.
// ---------------------------------------------------------------------------
// The block takes one item per cycle while results are taken as fast as they
// appear. Each accepted item's results come from a single result register in the
// cycle after acceptance, since the line store is a synchronous memory whose
// read data is registered. An overflowing character produces two results
// (LF then CR), which occupy the result register in turn, so that item holds
// off the next item until its CR leaves. The line store has no reset: it is only
// read below the current character count.
module terminal_input_line_buffer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tilb_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output tilb_pkg::out_item_t result
);
    import tilb_pkg::*;

    logic      accept;
    res_desc_t desc;
    mem_req_t  mem_req;

    logic [7:0] line_store_mem [LINE_CAPACITY];
    logic [7:0] rdata_reg;

    logic      pend_valid_reg;
    logic      pend_valid_next;
    res_desc_t pend_desc_reg;
    logic      second_reg;
    logic      second_next;
    logic      final_result;

    assign accept = item_valid && item_ready;

    tilb_line_ctrl u_line_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .desc    (desc),
        .mem_req (mem_req)
    );

    // Line store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            line_store_mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (accept)
        begin
            rdata_reg <= line_store_mem[mem_req.raddr];
        end
    end

    // Result register view.
    assign final_result    = !pend_desc_reg.two || second_reg;
    assign result_valid    = pend_valid_reg;
    assign result.dest     = pend_desc_reg.dest;
    assign result.out_byte = second_reg            ? CH_CR :
                             pend_desc_reg.use_mem ? rdata_reg : pend_desc_reg.byte0;
    assign result.last     = final_result;

    // A new item may enter once the last result of the previous one leaves.
    assign item_ready = !pend_valid_reg || (result_ready && final_result);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        second_next     = second_reg;
        if (accept)
        begin
            pend_valid_next = desc.valid;
            second_next     = 1'b0;
        end
        else if (pend_valid_reg && result_ready)
        begin
            if (final_result)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            second_reg     <= second_next;
        end
    end

    // Result description payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_desc_reg <= desc;
        end
    end

endmodule

[hdl/tilb_line_ctrl.sv]
// ---------------------------------------------------------------------------
// Terminal input line buffer: line control
// Holds the line counters and flags, and decides for each accepted item
// which results it produces and how the line store is accessed.
// ---------------------------------------------------------------------------
module tilb_line_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tilb_pkg::in_item_t  item,
    output tilb_pkg::res_desc_t desc,
    output tilb_pkg::mem_req_t  mem_req
);
    import tilb_pkg::*;

    logic [CNT_W-1:0] write_count_reg;
    logic [CNT_W-1:0] write_count_next;
    logic [CNT_W-1:0] read_index_reg;
    logic [CNT_W-1:0] read_index_next;
    logic             line_complete_reg;
    logic             line_complete_next;
    logic             reader_known_reg;
    logic             reader_known_next;

    // Decision logic for the item at the input.
    always_comb
    begin
        write_count_next   = write_count_reg;
        read_index_next    = read_index_reg;
        line_complete_next = line_complete_reg;
        reader_known_next  = reader_known_reg;

        desc         = '0;
        desc.dest    = DEST_ECHO;
        desc.byte0   = CH_LF;
        mem_req      = '0;
        mem_req.waddr = write_count_reg[ADDR_W-1:0];
        mem_req.wdata = item.rx_byte;
        mem_req.raddr = read_index_reg[ADDR_W-1:0];

        if (item.func == FUNC_RX)
        begin
            if (!line_complete_reg)
            begin
                if (item.rx_byte inside {CH_LF, CH_CR, CH_EOT})
                begin
                    // Line end: if a reader waits, push the first character, or LF for an empty line.
                    line_complete_next = 1'b1;
                    if (reader_known_reg)
                    begin
                        desc.valid = 1'b1;
                        desc.dest  = DEST_READER;
                        if (write_count_reg != '0)
                        begin
                            desc.use_mem    = 1'b1;
                            mem_req.raddr   = '0;
                            read_index_next = CNT_W'(1);
                        end
                        else
                        begin
                            line_complete_next = 1'b0;
                        end
                    end
                end
                else if (write_count_reg >= CAP_CNT)
                begin
                    // Overflow: echo LF then CR and empty the line.
                    desc.valid       = 1'b1;
                    desc.two         = 1'b1;
                    write_count_next = '0;
                end
                else
                begin
                    // Ordinary character: echo and store it.
                    desc.valid       = 1'b1;
                    desc.byte0       = item.rx_byte;
                    mem_req.we       = 1'b1;
                    write_count_next = write_count_reg + CNT_W'(1);
                end
            end
        end
        else
        begin
            desc.dest = DEST_READER;
            if (!line_complete_reg)
            begin
                reader_known_next = 1'b1;
            end
            else if (read_index_reg < write_count_reg)
            begin
                // Deliver the next stored character.
                desc.valid      = 1'b1;
                desc.use_mem    = 1'b1;
                read_index_next = read_index_reg + CNT_W'(1);
            end
            else
            begin
                // Whole line delivered: close it with LF and clear it.
                desc.valid         = 1'b1;
                write_count_next   = '0;
                read_index_next    = '0;
                line_complete_next = 1'b0;
            end
        end

        if (!accept)
        begin
            mem_req.we = 1'b0;
        end
    end

    // State registers, updated only when an item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg   <= '0;
            read_index_reg    <= '0;
            line_complete_reg <= 1'b0;
            reader_known_reg  <= 1'b0;
        end
        else if (accept)
        begin
            write_count_reg   <= write_count_next;
            read_index_reg    <= read_index_next;
            line_complete_reg <= line_complete_next;
            reader_known_reg  <= reader_known_next;
        end
    end

endmodule

[hdl/tilb_checker.sv]
// ---------------------------------------------------------------------------
// Terminal input line buffer: port checker
// Checks the behaviour seen on the top level's ports over time.
// ---------------------------------------------------------------------------
`include "terminal_input_line_buffer_core_macros.svh"

module tilb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input tilb_pkg::out_item_t result
);
    import tilb_pkg::*;

    logic res_stall;
    logic res_first;
    logic first_taken;
    logic echo_lf;
    logic res_cr_last;

    // Short names for the conditions that the checks look at.
    assign res_stall   = result_valid && !result_ready;
    assign res_first   = result_valid && !result.last;
    assign first_taken = res_first && result_ready;
    assign echo_lf     = result.dest == DEST_ECHO && result.out_byte == CH_LF;
    assign res_cr_last = result_valid && result.last && result.dest == DEST_ECHO
                         && result.out_byte == CH_CR;

    // A stalled result holds its value.
    `TILB_ASSERT_NEXT(a_result_hold, res_stall, result_valid && $stable(result), "result moved")

    // Only the overflow echo has a result that is not the item's last.
    `TILB_ASSERT_NOW(a_first_is_lf, res_first, echo_lf, "first of two not LF")

    // The overflow LF is followed at once by the final CR echo.
    `TILB_ASSERT_NEXT(a_cr_follows, first_taken, res_cr_last, "LF not followed by CR")

    // No new item enters while an item's first of two results waits.
    `TILB_ASSERT_NOW(a_no_entry_mid, res_first, !(item_valid && item_ready), "item taken mid pair")

endmodule

bind terminal_input_line_buffer_core tilb_checker u_tilb_checker (.*);

[bench/line_discipline_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Line discipline checker
// Watches both channels of the terminal input line buffer. It keeps its own
// copy of the line store, counters and flags, works out the echo and reader
// characters that each accepted item should cause, and compares each
// accepted result with the oldest character still owed.
// ---------------------------------------------------------------------------
module line_discipline_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  tilb_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  tilb_pkg::out_item_t result,
    output int                  mismatch_count,
    output int                  chars_owed
);
    import tilb_pkg::*;

    // Shadow of the line state.
    logic [7:0]       line_mem [LINE_CAPACITY];
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] deliver_idx;
    logic             line_waiting;
    logic             reader_seen;

    // Characters owed by the block, oldest first.
    out_item_t expected_chars [$];

    function automatic out_item_t char_to(input logic dest, input logic [7:0] ch);
        out_item_t r;
        r.dest     = dest;
        r.out_byte = ch;
        r.last     = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Advance the shadow state by one accepted item and queue what it owes.
    task automatic predict_line_response(input in_item_t it);
        out_item_t res [2];
        int        n;
        n = 0;
        if (it.func == FUNC_RX)
        begin
            // Received bytes are dropped while a finished line waits.
            if (!line_waiting)
            begin
                if (it.rx_byte == CH_LF || it.rx_byte == CH_CR || it.rx_byte == CH_EOT)
                begin
                    line_waiting = 1'b1;
                    if (reader_seen)
                    begin
                        if (fill_count != '0)
                        begin
                            res[n] = char_to(DEST_READER, line_mem[0]);
                            n++;
                            deliver_idx = CNT_W'(1);
                        end
                        else
                        begin
                            // An empty line hands the reader LF and is gone.
                            res[n] = char_to(DEST_READER, CH_LF);
                            n++;
                            line_waiting = 1'b0;
                        end
                    end
                end
                else if (fill_count >= CAP_CNT)
                begin
                    // Full store: new line on the terminal and start afresh.
                    res[0] = char_to(DEST_ECHO, CH_LF);
                    res[1] = char_to(DEST_ECHO, CH_CR);
                    n = 2;
                    fill_count = '0;
                end
                else
                begin
                    res[n] = char_to(DEST_ECHO, it.rx_byte);
                    n++;
                    line_mem[fill_count[ADDR_W-1:0]] = it.rx_byte;
                    fill_count++;
                end
            end
        end
        else
        begin
            if (!line_waiting)
                reader_seen = 1'b1;
            else if (deliver_idx < fill_count)
            begin
                res[n] = char_to(DEST_READER, line_mem[deliver_idx[ADDR_W-1:0]]);
                n++;
                deliver_idx++;
            end
            else
            begin
                // Whole line delivered: closing LF clears it.
                res[n] = char_to(DEST_READER, CH_LF);
                n++;
                fill_count   = '0;
                deliver_idx  = '0;
                line_waiting = 1'b0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            res[i].last = (i == n - 1);
            expected_chars.push_back(res[i]);
        end
    endtask

    // Predict on each accepted item, then check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fill_count     = '0;
            deliver_idx    = '0;
            line_waiting   = 1'b0;
            reader_seen    = 1'b0;
            mismatch_count = 0;
            expected_chars.delete();
        end
        else
        begin
            if (item_valid && item_ready)
                predict_line_response(item);
            if (result_valid && result_ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("result with nothing owed", result.out_byte, 8'h00);
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.dest !== want.dest)
                        report_mismatch("dest", {7'b0, result.dest}, {7'b0, want.dest});
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte", result.out_byte, want.out_byte);
                    if (result.last !== want.last)
                        report_mismatch("last", {7'b0, result.last}, {7'b0, want.last});
                end
            end
        end
        chars_owed = expected_chars.size();
    end

endmodule

[bench/tb_terminal_input_line_buffer_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Terminal input line buffer testbench
// Drives received bytes and reader requests into the line buffer: a short
// directed run through the line-ending, reader and empty-line cases, and
// then random lines, mostly well formed. The checker beside the block does
// all prediction and comparison; this module only makes stimulus, idles both
// sides in short random bursts and gives the verdict.
// ---------------------------------------------------------------------------
module tb_terminal_input_line_buffer_core;
    import tilb_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    int mismatch_count;
    int chars_owed;
    int cycle_count = 0;
    int idle_odds   = 3;
    int stall_left  = 0;

    always #HALF_PERIOD clk = ~clk;

    terminal_input_line_buffer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    line_discipline_checker line_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .mismatch_count (mismatch_count),
        .chars_owed     (chars_owed)
    );

    // Result side: ready drops in short random bursts unless idling is off.
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            stall_left = $urandom_range(1, 4);
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one item from a falling edge and return at the falling edge after
    // it is taken.
    task automatic send_item(input logic func, input logic [7:0] ch);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 4);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{func: func, rx_byte: ch};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Any byte that does not end a line.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF || b == CH_CR || b == CH_EOT)
            b = b ^ 8'h40;
        return b;
    endfunction

    // One of the three characters that finish a line.
    function automatic logic [7:0] term_char();
        case ($urandom_range(0, 2))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return CH_EOT;
        endcase
    endfunction

    initial
    begin
        int counted;
        int len;
        int reqs;
        int pick;
        int noise;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a line finished before any reader has asked waits silently.
        send_item(FUNC_RX, 8'h61);
        send_item(FUNC_RX, 8'h00);
        send_item(FUNC_RX, 8'hFF);
        send_item(FUNC_RX, CH_CR);
        // Ignored while the line waits.
        send_item(FUNC_RX, 8'h7A);
        // The reader pulls it out, then the closing LF clears it.
        send_item(FUNC_REQ, 8'h00);
        send_item(FUNC_REQ, 8'hFF);
        send_item(FUNC_REQ, 8'h55);
        send_item(FUNC_REQ, 8'hAA);
        // Request with nothing ready records the reader.
        send_item(FUNC_REQ, 8'h0A);
        // Empty line with a known reader gives LF alone.
        send_item(FUNC_RX, CH_LF);
        // A finished line now pushes its first character at once.
        send_item(FUNC_RX, 8'h55);
        send_item(FUNC_RX, 8'hAA);
        send_item(FUNC_RX, CH_EOT);
        send_item(FUNC_REQ, 8'h04);
        send_item(FUNC_REQ, 8'h0D);
        // Extra request after the line has gone.
        send_item(FUNC_REQ, 8'h80);
        send_item(FUNC_RX, 8'h01);
        send_item(FUNC_RX, CH_CR);
        send_item(FUNC_REQ, 8'h7F);

        // Random lines, with some noise and some broken reads.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= RANDOM_ITEMS - CALM_ITEMS)
                idle_odds = 0;
            else if ($urandom_range(0, 7) == 0)
                idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                counted++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(0, 8);
                repeat (len) send_item(FUNC_RX, plain_char());
                send_item(FUNC_RX, term_char());
                // Bytes typed while the line waits are dropped.
                noise = $urandom_range(0, 2);
                repeat (noise) send_item(FUNC_RX, 8'($urandom_range(0, 255)));
                reqs = len;
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    reqs = $urandom_range(0, len);
                else if (pick == 1)
                    reqs = len + $urandom_range(1, 2);
                repeat (reqs) send_item(FUNC_REQ, 8'($urandom_range(0, 255)));
                counted += len + 1 + noise + reqs;
            end
        end
        item_valid <= 1'b0;

        // Drain, then wait out DRAIN_CYCLES for anything stray.
        @(negedge clk);
        while (chars_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && chars_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
